>>> design/bdq_pkg.sv
package bdq_pkg;

    localparam int CAP_W = 11;
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_QUERY      = 3'd4;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] value;
    } t_dq_in;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] front_value;
        logic signed [31:0] rear_value;
        logic               is_empty;
        logic               is_full;
    } t_dq_out;

endpackage

>>> design/bdq_ram.sv
module bdq_ram import bdq_pkg::*; #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [31:0]   o_rdata_a,
    output logic [31:0]   o_rdata_b
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata_a;
    logic [31:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Write-first: a read of the entry being written sees the new word.
    always_ff @(posedge i_clk) begin
        if (i_we && i_waddr == i_raddr_a) begin
            r_rdata_a <= i_wdata;
        end else begin
            r_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_we && i_waddr == i_raddr_b) begin
            r_rdata_b <= i_wdata;
        end else begin
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> design/bounded_double_ended_queue_unit.sv
// Bounded deque of signed 32-bit words kept as a ring in one synchronous
// RAM, tracked by a head index and an entry count. A command is taken when
// i_start is high and o_busy is low; its result appears on o_res for exactly
// one cycle, flagged by o_res_valid, in the cycle right after acceptance, and
// must be captured then since it cannot be held off. Each command first updates
// head and count, writes the pushed word and issues the front and rear reads,
// then waits on the RAM read, which o_busy covers. Capacity must be written
// through the cfg channel while the unit is idle; the block does not enforce
// it. Values above DEPTH act as DEPTH. There is no clearing pass after reset.
module bounded_double_ended_queue_unit import bdq_pkg::*; #(
    parameter int DEPTH = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  t_dq_in           i_cmd,
    output logic             o_res_valid,
    output t_dq_out          o_res,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CAP_W-1:0] i_cfg_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;
    localparam int SW = ((AW > CW) ? AW : CW) + 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
    localparam logic [LW-1:0] DEPTH_L  = LW'(DEPTH);

    logic             r_busy;
    logic [AW-1:0]    r_head;
    logic [CW-1:0]    r_count;
    logic [CAP_W-1:0] r_cap;
    logic             r_ok;
    logic             r_empty;
    logic             r_full;

    logic [AW-1:0]    n_head;
    logic [CW-1:0]    n_count;
    logic             n_ok;
    logic             accept;
    logic [LW-1:0]    cap_l;
    logic [LW-1:0]    eff_cap;
    logic             full_now;
    logic             full_next;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [SW-1:0]    back_sum;
    logic [AW-1:0]    back_addr;
    logic [SW-1:0]    rear_sum;
    logic [AW-1:0]    rear_addr;
    logic [31:0]      rdata_front;
    logic [31:0]      rdata_rear;

    assign accept      = i_start && !r_busy;
    assign o_busy      = r_busy;
    assign o_cfg_ready = 1'b1;

    assign cap_l    = LW'(r_cap);
    assign eff_cap  = (cap_l > DEPTH_L) ? DEPTH_L : cap_l;
    assign full_now = LW'(r_count) >= eff_cap;

    // Slot just past the rear; count stays below DEPTH when a push is taken.
    assign back_sum  = SW'(r_head) + SW'(r_count);
    assign back_addr = (back_sum >= DEPTH_S) ? AW'(back_sum - DEPTH_S) : AW'(back_sum);

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        n_ok    = 1'b1;
        we      = 1'b0;
        waddr   = back_addr;
        case (i_cmd.op)
            OP_PUSH_FRONT: begin
                if (full_now) begin
                    n_ok = 1'b0;
                end else begin
                    n_head  = (r_head == '0) ? LAST_IDX : r_head - AW'(1);
                    n_count = r_count + CW'(1);
                    we      = 1'b1;
                    waddr   = n_head;
                end
            end
            OP_PUSH_BACK: begin
                if (full_now) begin
                    n_ok = 1'b0;
                end else begin
                    n_count = r_count + CW'(1);
                    we      = 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (r_count == '0) begin
                    n_ok = 1'b0;
                end else begin
                    n_head  = (r_head == LAST_IDX) ? '0 : r_head + AW'(1);
                    n_count = r_count - CW'(1);
                end
            end
            OP_POP_BACK: begin
                if (r_count == '0) begin
                    n_ok = 1'b0;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            default: begin
                n_ok = 1'b1;
            end
        endcase
    end

    assign full_next = LW'(n_count) >= eff_cap;

    // Rear of the updated queue; an empty queue reads the head slot, masked later.
    assign rear_sum  = SW'(n_head) + SW'(n_count) - SW'(1);
    assign rear_addr = (n_count == '0) ? n_head :
                       (rear_sum >= DEPTH_S) ? AW'(rear_sum - DEPTH_S) : AW'(rear_sum);

    bdq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (accept && we),
        .i_waddr   (waddr),
        .i_wdata   (i_cmd.value),
        .i_raddr_a (n_head),
        .i_raddr_b (rear_addr),
        .o_rdata_a (rdata_front),
        .o_rdata_b (rdata_rear)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_head  <= '0;
            r_count <= '0;
            r_cap   <= CAP_RESET;
        end else begin
            r_busy <= accept;
            if (accept) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ok    <= n_ok;
            r_empty <= (n_count == '0);
            r_full  <= full_next;
        end
    end

    assign o_res_valid       = r_busy;
    assign o_res.ok          = r_ok;
    assign o_res.front_value = r_empty ? -32'sd1 : $signed(rdata_front);
    assign o_res.rear_value  = r_empty ? -32'sd1 : $signed(rdata_rear);
    assign o_res.is_empty    = r_empty;
    assign o_res.is_full     = r_full;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LW'(r_count) <= DEPTH_L)
        else $error("entry count exceeds store depth");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SW'(r_head) < DEPTH_S)
        else $error("head index outside store");

    a_refused_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.ok) |-> ($stable(r_count) && $stable(r_head)))
        else $error("refused word changed queue state");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.is_empty == (r_count == '0)))
        else $error("empty flag disagrees with count");
`endif

endmodule

>>> tb/tb_top.sv
module tb_top;
    import bdq_pkg::*;

    localparam int DEPTH = 1024;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_start = 1'b0;
    logic             o_busy;
    t_dq_in           i_cmd = '0;
    logic             o_res_valid;
    t_dq_out          o_res;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CAP_W-1:0] i_cfg_data = '0;

    // shadow deque, advanced once per accepted word
    logic [31:0]      ring_mem [DEPTH];
    int               ring_head = 0;
    int               ring_count = 0;
    logic [CAP_W-1:0] cap_reg = CAP_RESET;

    t_dq_out          due_results [$];
    int               err_count = 0;
    int               burst_left = 12;

    bounded_double_ended_queue_unit #(.DEPTH(DEPTH)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_cmd       (i_cmd),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_dq_out apply_deque_op(t_dq_in cmd);
        t_dq_out view;
        int      limit;
        limit = (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
        view.ok = 1'b1;
        case (cmd.op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (ring_count >= limit) begin
                    view.ok = 1'b0;
                end else if (cmd.op == OP_PUSH_FRONT) begin
                    ring_head = (ring_head + DEPTH - 1) % DEPTH;
                    ring_mem[ring_head] = cmd.value;
                    ring_count++;
                end else begin
                    ring_mem[(ring_head + ring_count) % DEPTH] = cmd.value;
                    ring_count++;
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (ring_count == 0) begin
                    view.ok = 1'b0;
                end else begin
                    if (cmd.op == OP_POP_FRONT)
                        ring_head = (ring_head + 1) % DEPTH;
                    ring_count--;
                end
            end
            default: ;  // query, and the unused codes behave the same
        endcase
        if (ring_count != 0) begin
            view.front_value = ring_mem[ring_head];
            view.rear_value  = ring_mem[(ring_head + ring_count - 1) % DEPTH];
        end else begin
            view.front_value = -32'sd1;
            view.rear_value  = -32'sd1;
        end
        view.is_empty = (ring_count == 0);
        view.is_full  = (ring_count >= limit);
        return view;
    endfunction

    always @(posedge i_clk) begin
        t_dq_out want;
        if (i_rst_n) begin
            if (o_res_valid) begin
                if (due_results.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("unexpected result word ok %0b front %0d rear %0d",
                                 o_res.ok, o_res.front_value, o_res.rear_value);
                end else begin
                    want = due_results.pop_front();
                    if (o_res.ok !== want.ok || o_res.front_value !== want.front_value ||
                        o_res.rear_value !== want.rear_value ||
                        o_res.is_empty !== want.is_empty || o_res.is_full !== want.is_full)
                    begin
                        err_count++;
                        if (err_count <= 10) begin
                            $display("mismatch exp: ok %0b front %0d rear %0d empty %0b full %0b",
                                     want.ok, want.front_value, want.rear_value,
                                     want.is_empty, want.is_full);
                            $display("         got: ok %0b front %0d rear %0d empty %0b full %0b",
                                     o_res.ok, o_res.front_value, o_res.rear_value,
                                     o_res.is_empty, o_res.is_full);
                        end
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready)
                cap_reg = i_cfg_data;
            if (i_start && !o_busy)
                due_results.push_back(apply_deque_op(i_cmd));
        end
    end

    function automatic t_dq_in make_cmd(logic [2:0] op, logic [31:0] value);
        t_dq_in c;
        c.op    = op;
        c.value = value;
        return c;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // push_pct of the words push; most of the rest pop, a few query
    function automatic t_dq_in random_cmd(int push_pct);
        t_dq_in c;
        int     r;
        r = $urandom_range(99);
        if (r < push_pct)
            c.op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        else if (r < push_pct + (100 - push_pct) * 85 / 100)
            c.op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
        else
            c.op = 3'($urandom_range(int'(OP_QUERY), 7));
        c.value = pick_value();
        return c;
    endfunction

    // call at a rising-edge step; returns at the edge that takes the word
    task automatic send_cmd(input t_dq_in cmd);
        i_start <= 1'b1;
        i_cmd   <= cmd;
        do @(posedge i_clk); while (o_busy);
    endtask

    // send one word, then drop start for a random gap at the end of a burst
    task automatic stream_item(input t_dq_in cmd);
        send_cmd(cmd);
        burst_left--;
        if (burst_left <= 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    // hold off until every result is back and the unit has gone quiet
    task automatic settle();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [CAP_W-1:0] cap, input int count, input int push_pct);
        settle();
        write_capacity(cap);
        repeat (count) stream_item(random_cmd(push_pct));
    endtask

    task automatic test_empty_and_ops();
        stream_item(make_cmd(OP_QUERY, $urandom));
        stream_item(make_cmd(OP_POP_FRONT, $urandom));
        stream_item(make_cmd(OP_POP_BACK, $urandom));
        stream_item(make_cmd(OP_PUSH_FRONT, 32'h8000_0000));
        stream_item(make_cmd(OP_PUSH_BACK, 32'h7fff_ffff));
        stream_item(make_cmd(OP_PUSH_FRONT, 32'h0000_0000));
        stream_item(make_cmd(OP_PUSH_BACK, 32'hffff_ffff));
        stream_item(make_cmd(3'd5, $urandom));
        stream_item(make_cmd(3'd6, $urandom));
        stream_item(make_cmd(3'd7, $urandom));
        stream_item(make_cmd(OP_POP_FRONT, $urandom));
        stream_item(make_cmd(OP_POP_BACK, $urandom));
        stream_item(make_cmd(OP_POP_BACK, $urandom));
        stream_item(make_cmd(OP_POP_FRONT, $urandom));
    endtask

    task automatic test_zero_capacity();
        settle();
        write_capacity('0);
        stream_item(make_cmd(OP_PUSH_FRONT, $urandom));
        stream_item(make_cmd(OP_PUSH_BACK, $urandom));
        stream_item(make_cmd(OP_POP_FRONT, $urandom));
        stream_item(make_cmd(OP_QUERY, $urandom));
    endtask

    // lower the limit under the live count: pushes refused, nothing dropped
    task automatic test_capacity_shrink();
        settle();
        write_capacity(11'd3);
        repeat (3) stream_item(make_cmd(OP_PUSH_BACK, $urandom));
        stream_item(make_cmd(OP_PUSH_FRONT, $urandom));
        settle();
        write_capacity(11'd1);
        stream_item(make_cmd(OP_PUSH_BACK, $urandom));
        stream_item(make_cmd(OP_POP_FRONT, $urandom));
        stream_item(make_cmd(OP_POP_BACK, $urandom));
        stream_item(make_cmd(OP_POP_FRONT, $urandom));
        stream_item(make_cmd(OP_PUSH_FRONT, $urandom));
    endtask

    task automatic test_random_mix();
        run_phase(11'd1, 30, 50);
        run_phase(11'd2, 30, 50);
        run_phase(11'd7, 40, 55);
        run_phase(CAP_W'($urandom_range(3, 64)), 50, 60);
        run_phase(CAP_W'($urandom_range(1025, 2047)), 30, 50);
        run_phase('0, 10, 50);
    endtask

    // fill up to the store depth with the register above it, then work at full
    task automatic test_fill_to_depth();
        run_phase(11'd2047, 1150, 97);
        run_phase(CAP_RESET, 80, 30);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_and_ops();
        test_zero_capacity();
        test_capacity_shrink();
        test_random_mix();
        test_fill_to_depth();
        settle();
        if (due_results.size() != 0) begin
            $display("%0d expected results never arrived", due_results.size());
            err_count += due_results.size();
        end
        if (err_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        #1000000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

>>> bounded_double_ended_queue_unit.f
design/bdq_pkg.sv
design/bdq_ram.sv
design/bounded_double_ended_queue_unit.sv
tb/tb_top.sv
